FILE: design/mrf_pkg.sv
// mrf_pkg: shared constants, widths, types and state codes of the Modbus RTU response framer
// no dependencies; imported by the channel interfaces and all framer modules
`timescale 1ns / 1ps

package mrf_pkg;

  // sizing
  localparam int LINKS          = 4;
  localparam int STORE_DEPTH    = 256;
  localparam int MAX_BYTE_COUNT = 125;

  // fixed field widths
  localparam int LINK_W = 2;
  localparam int BYTE_W = 8;
  localparam int VCNT_W = 3;

  // framing constants
  localparam int MIN_HELD  = 5;
  localparam int EXC_LEN   = 5;
  localparam int WRITE_LEN = 8;
  localparam int EXC_BIT   = 7;
  localparam int BEAT_BYTES = 4;
  localparam logic [BYTE_W-1:0] FN_READ_HOLDING = 8'h03;
  localparam logic [BYTE_W-1:0] FN_WRITE_SINGLE = 8'h06;
  localparam logic [BYTE_W-1:0] FN_WRITE_MULTI  = 8'h10;

  // derived widths
  localparam int FRAME_MAX = (EXC_LEN + MAX_BYTE_COUNT > WRITE_LEN) ?
                             EXC_LEN + MAX_BYTE_COUNT : WRITE_LEN;
  localparam int LEN_W      = $clog2(FRAME_MAX + 1);
  localparam int PTR_W      = $clog2(STORE_DEPTH);
  localparam int HELD_W     = $clog2(STORE_DEPTH + 1);
  localparam int SUM_W      = HELD_W + 1;
  localparam int CMP_W      = (HELD_W > LEN_W) ? HELD_W : LEN_W;
  localparam int ADDR_W     = $clog2(LINKS * STORE_DEPTH);
  localparam int LINK_IDX_W = (LINKS > 1) ? $clog2(LINKS) : 1;

  // one received byte queued between front and back
  typedef struct packed {
    logic [LINK_W-1:0] link;
    logic [BYTE_W-1:0] data;
  } item_t;

  // back-end sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FUNC,
    ST_COUNT,
    ST_BEAT,
    ST_LAST,
    ST_PUSH
  } back_state_t;

endpackage

FILE: design/mrf_in_if.sv
// mrf_in_if: received-byte channel, valid/ready with link number and byte
// depends on mrf_pkg
`timescale 1ns / 1ps

interface mrf_in_if;
  import mrf_pkg::*;

  logic              valid;
  logic              ready;
  logic [LINK_W-1:0] link;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output link, output rx_byte, input ready);
  modport sink   (input valid, input link, input rx_byte, output ready);
endinterface

FILE: design/mrf_out_if.sv
// mrf_out_if: frame beat channel, valid/ready with link, four bytes, count and end mark
// depends on mrf_pkg
`timescale 1ns / 1ps

interface mrf_out_if;
  import mrf_pkg::*;

  logic              valid;
  logic              ready;
  logic [LINK_W-1:0] out_link;
  logic [BYTE_W-1:0] byte0;
  logic [BYTE_W-1:0] byte1;
  logic [BYTE_W-1:0] byte2;
  logic [BYTE_W-1:0] byte3;
  logic [VCNT_W-1:0] valid_count;
  logic              frame_end;

  modport source (output valid, output out_link, output byte0, output byte1, output byte2,
                  output byte3, output valid_count, output frame_end, input ready);
  modport sink   (input valid, input out_link, input byte0, input byte1, input byte2,
                  input byte3, input valid_count, input frame_end, output ready);
endinterface

FILE: design/modbus_rtu_response_framer_core.sv
// modbus_rtu_response_framer_core: top level of the Modbus RTU response framer
// depends on mrf_pkg, mrf_in_if, mrf_out_if, mrf_front, mrf_back
`timescale 1ns / 1ps

// Received bytes arrive on rx, each tagged with its serial link, and are appended to
// that link's circular byte store (STORE_DEPTH bytes per link). Frames are cut by length
// only, no CRC check: an exception response (function top bit set) is 5 bytes, function
// 03 is 5 plus its byte count, functions 06 and 10 are 8 bytes; a bad count or an
// unknown function drops the oldest byte to resynchronise, and nothing is decided with
// fewer than 5 bytes held. A finished frame leaves on beats as 4-byte beats with
// valid_count and frame_end; unused bytes of a short beat are zero. Bytes of a link number
// at or above LINKS are accepted and discarded. Timing: the front takes a byte whenever its
// two-entry queue has room, so short bursts are absorbed. The back sequencer owns the
// byte store, whose read data is registered, and takes a queued byte only while idle; after
// each byte it checks how many are held and, from 5 on, reads the header, then cuts any
// ready frame, reading each beat byte by byte and holding it while the sink stalls.
// The store needs no clearing after reset: only bytes that were written are ever read.
module modbus_rtu_response_framer_core (
  input logic       clk,
  input logic       rst,
  mrf_in_if.sink    rx,
  mrf_out_if.source beats
);
  import mrf_pkg::*;

  // queue head handed from front to back
  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  // front: accept, filter by link, queue
  mrf_front u_front (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  // back: store, frame cutting, beat output register
  mrf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .beats   (beats)
  );

endmodule

FILE: design/mrf_front.sv
// mrf_front: accepts received bytes, discards those of links out of range, queues the rest
// depends on mrf_pkg and mrf_in_if; feeds mrf_back
`timescale 1ns / 1ps

module mrf_front (
  input  logic          clk,
  input  logic          rst,
  mrf_in_if.sink        rx,
  output mrf_pkg::item_t q_item,
  output logic          q_valid,
  input  logic          q_pop
);
  import mrf_pkg::*;

  localparam int Q_DEPTH = 2;

  item_t      q_mem [Q_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] q_count;
  logic       accept;
  logic       link_ok;
  logic       push;

  assign rx.ready = (q_count < 2'(Q_DEPTH));
  assign accept   = rx.valid && rx.ready;
  assign link_ok  = (32'(rx.link) < LINKS);
  assign push     = accept && link_ok;

  assign q_valid  = (q_count != 2'd0);
  assign q_item   = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= 1'b0;
      rd_ptr  <= 1'b0;
      q_count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      unique case ({push, q_pop})
        2'b10:   q_count <= q_count + 2'd1;
        2'b01:   q_count <= q_count - 2'd1;
        default: q_count <= q_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr].link <= rx.link;
      q_mem[wr_ptr].data <= rx.rx_byte;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= 2'(Q_DEPTH))
    else $error("front queue count beyond its depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_count != 2'd0)
    else $error("front queue popped while empty");

endmodule

FILE: design/mrf_back.sv
// mrf_back: per-link byte store, length-based frame cutting and beat emission
// depends on mrf_pkg and mrf_out_if; takes items from mrf_front
`timescale 1ns / 1ps

module mrf_back (
  input  logic           clk,
  input  logic           rst,
  input  mrf_pkg::item_t q_item,
  input  logic           q_valid,
  output logic           q_pop,
  mrf_out_if.source      beats
);
  import mrf_pkg::*;

  function automatic logic [PTR_W-1:0] wrap(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    r = (s >= SUM_W'(STORE_DEPTH)) ? s - SUM_W'(STORE_DEPTH) : s;
    return r[PTR_W-1:0];
  endfunction

  back_state_t state;
  back_state_t state_next;

  logic [BYTE_W-1:0] store [LINKS * STORE_DEPTH];
  logic [BYTE_W-1:0] rdata;
  logic [PTR_W-1:0]  head [LINKS];
  logic [HELD_W-1:0] held [LINKS];

  logic [LINK_W-1:0]     cur_link;
  logic [LINK_IDX_W-1:0] li;
  logic [PTR_W-1:0]      head_cur;
  logic [HELD_W-1:0]     held_cur;

  logic [BYTE_W-1:0] fn;
  logic [LEN_W-1:0]  len_r;
  logic [LEN_W-1:0]  pos;
  logic [1:0]        k;
  logic [BYTE_W-1:0] beat [BEAT_BYTES];
  logic              cap_valid;
  logic [1:0]        cap_idx;

  logic [HELD_W-1:0] rd_off;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              do_write;
  logic              drop1;
  logic              drop_frame;
  logic              start_frame;
  logic              push;
  logic              slot_free;

  logic              bad_hdr;
  logic [LEN_W-1:0]  len_calc;
  logic [LEN_W-1:0]  rem;
  logic [VCNT_W-1:0] cnt;
  logic              last_k;
  logic              frame_last;

  // current link: the queued item's link while idle, else the one in progress
  assign li       = (state == ST_IDLE) ? LINK_IDX_W'(q_item.link) : LINK_IDX_W'(cur_link);
  assign head_cur = head[li];
  assign held_cur = held[li];

  assign rd_addr = ADDR_W'(li) * ADDR_W'(STORE_DEPTH)
                 + ADDR_W'(wrap(SUM_W'(head_cur) + SUM_W'(rd_off)));
  assign wr_addr = ADDR_W'(li) * ADDR_W'(STORE_DEPTH)
                 + ADDR_W'(wrap(SUM_W'(head_cur) + SUM_W'(held_cur)));

  // header decode, rdata holds the byte count while in ST_COUNT
  always_comb begin
    bad_hdr  = 1'b0;
    len_calc = LEN_W'(WRITE_LEN);
    if (fn[EXC_BIT]) begin
      len_calc = LEN_W'(EXC_LEN);
    end else if (fn == FN_READ_HOLDING) begin
      bad_hdr  = (rdata == '0) || (32'(rdata) > MAX_BYTE_COUNT);
      len_calc = LEN_W'(EXC_LEN) + LEN_W'(rdata);
    end else if (fn == FN_WRITE_SINGLE || fn == FN_WRITE_MULTI) begin
      len_calc = LEN_W'(WRITE_LEN);
    end else begin
      bad_hdr = 1'b1;
    end
  end

  assign rem        = len_r - pos;
  assign cnt        = (rem > LEN_W'(BEAT_BYTES)) ? VCNT_W'(BEAT_BYTES) : VCNT_W'(rem);
  assign frame_last = (rem <= LEN_W'(BEAT_BYTES));
  assign last_k     = (VCNT_W'(k) + VCNT_W'(1) == cnt);
  assign slot_free  = !beats.valid || beats.ready;

  always_comb begin
    state_next  = state;
    rd_off      = '0;
    q_pop       = 1'b0;
    do_write    = 1'b0;
    drop1       = 1'b0;
    drop_frame  = 1'b0;
    start_frame = 1'b0;
    push        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          do_write   = (held_cur < HELD_W'(STORE_DEPTH));
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (held_cur < HELD_W'(MIN_HELD)) begin
          state_next = ST_IDLE;
        end else begin
          rd_off     = HELD_W'(1);
          state_next = ST_FUNC;
        end
      end
      ST_FUNC: begin
        rd_off     = HELD_W'(2);
        state_next = ST_COUNT;
      end
      ST_COUNT: begin
        if (bad_hdr) begin
          drop1      = 1'b1;
          state_next = ST_CHECK;
        end else if (CMP_W'(held_cur) < CMP_W'(len_calc)) begin
          state_next = ST_IDLE;
        end else begin
          start_frame = 1'b1;
          state_next  = ST_BEAT;
        end
      end
      ST_BEAT: begin
        rd_off = HELD_W'(pos) + HELD_W'(k);
        if (last_k) state_next = ST_LAST;
      end
      ST_LAST: begin
        state_next = ST_PUSH;
      end
      ST_PUSH: begin
        if (slot_free) begin
          push = 1'b1;
          if (frame_last) begin
            drop_frame = 1'b1;
            state_next = ST_CHECK;
          end else begin
            state_next = ST_BEAT;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cap_valid   <= 1'b0;
      beats.valid <= 1'b0;
      for (int i = 0; i < LINKS; i++) begin
        head[i] <= '0;
        held[i] <= '0;
      end
    end else begin
      state     <= state_next;
      cap_valid <= (state == ST_BEAT);
      if (push) beats.valid <= 1'b1;
      else if (beats.ready) beats.valid <= 1'b0;
      if (do_write) held[li] <= held_cur + HELD_W'(1);
      if (drop1) begin
        head[li] <= wrap(SUM_W'(head_cur) + SUM_W'(1));
        held[li] <= held_cur - HELD_W'(1);
      end
      if (drop_frame) begin
        head[li] <= wrap(SUM_W'(head_cur) + SUM_W'(len_r));
        held[li] <= held_cur - HELD_W'(len_r);
      end
    end
  end

  // byte store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (do_write) store[wr_addr] <= q_item.data;
    rdata <= store[rd_addr];
  end

  // datapath
  always_ff @(posedge clk) begin
    if (q_pop) cur_link <= q_item.link;
    if (state == ST_FUNC) fn <= rdata;
    cap_idx <= k;
    if (cap_valid) beat[cap_idx] <= rdata;
    if (start_frame) begin
      len_r <= len_calc;
      pos   <= '0;
      k     <= '0;
    end else if (state == ST_BEAT && !last_k) begin
      k <= k + 2'd1;
    end else if (push) begin
      pos <= pos + LEN_W'(cnt);
      k   <= '0;
    end
    if (push) begin
      beats.out_link    <= cur_link;
      beats.byte0       <= beat[0];
      beats.byte1       <= (cnt > VCNT_W'(1)) ? beat[1] : '0;
      beats.byte2       <= (cnt > VCNT_W'(2)) ? beat[2] : '0;
      beats.byte3       <= (cnt > VCNT_W'(3)) ? beat[3] : '0;
      beats.valid_count <= cnt;
      beats.frame_end   <= frame_last;
    end
  end

  a_vcount_range: assert property (@(posedge clk) disable iff (rst)
    beats.valid |-> (beats.valid_count != '0) && (beats.valid_count <= VCNT_W'(BEAT_BYTES)))
    else $error("beat valid count out of range");

  a_short_is_end: assert property (@(posedge clk) disable iff (rst)
    beats.valid && (beats.valid_count != VCNT_W'(BEAT_BYTES)) |-> beats.frame_end)
    else $error("partial beat that is not the frame end");

  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    beats.valid && (beats.valid_count != VCNT_W'(BEAT_BYTES)) |-> beats.byte3 == '0)
    else $error("unused beat byte not cleared");

  a_frame_held: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BEAT) |-> CMP_W'(held_cur) >= CMP_W'(len_r))
    else $error("frame emitted with fewer bytes held than its length");

endmodule
